### rtl/core/assert_macros.svh
// Assertion macros used by the top level of the 3x3 box filter.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/core/bb3_pkg.sv
// Shared constants, types and helper functions of the 3x3 box filter.
// Depends on nothing; all RTL but the line RAM and assert macros use it.
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = PIX_W + 4;
  localparam int CNT_W      = 4;
  localparam int RECIP_SH   = 16;
  localparam int RECIP_W    = RECIP_SH + 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_CALC = 3'b100
  } state_t;

  // New column entering the window: upper row, middle row, current pixel.
  typedef struct packed {
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] pix;
  } col_t;

  // Which neighbors of the output position lie inside the frame.
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } mask_t;

  typedef struct packed {
    logic eor;
    logic eof;
  } res_flags_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  // ceil(2^16 / n): exact truncated quotient for any sum below 2^12.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = RECIP_W'(65536);
      4'd2:    r = RECIP_W'(32768);
      4'd3:    r = RECIP_W'(21846);
      4'd4:    r = RECIP_W'(16384);
      4'd6:    r = RECIP_W'(10923);
      4'd9:    r = RECIP_W'(7282);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/bb3_if.sv
// Stream interfaces of the 3x3 box filter: pixel input and result output.
// Depends on bb3_pkg for the field widths.
interface bb3_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [bb3_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output op, output pixel_in, input ready);
  modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface bb3_out_if;
  logic                       valid;
  logic                       ready;
  logic [bb3_pkg::PIX_W-1:0]  blurred_pixel;
  logic                       end_of_row;
  logic                       end_of_frame;

  modport source (output valid, output blurred_pixel, output end_of_row,
                  output end_of_frame, input ready);
  modport sink   (input valid, input blurred_pixel, input end_of_row,
                  input end_of_frame, output ready);
endinterface

### rtl/core/bb3_line_ram.sv
// Simple dual-port synchronous RAM with registered read data.
// Holds both line stores of the filter; depends on nothing.
module bb3_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/bb3_window.sv
// 3x3 window of pixel cells and the masked sum and count of its cells.
// Depends on bb3_pkg for col_t, mask_t and widths.
module bb3_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift,
  input  bb3_pkg::col_t              col_in,
  input  bb3_pkg::mask_t             mask,
  output logic [bb3_pkg::SUM_W-1:0]  sum_r,
  output logic [bb3_pkg::CNT_W-1:0]  cnt_r
);
  import bb3_pkg::*;

  logic [PIX_W-1:0] win_r   [3][3];
  logic [PIX_W-1:0] win_nxt [3][3];
  logic [SUM_W-1:0] row_sum [3];
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic [2:0]       row_ok;
  logic [2:0]       col_ok;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = col_in.up;
    win_nxt[1][2] = col_in.lo;
    win_nxt[2][2] = col_in.pix;
  end

  assign row_ok = {mask.bot, 1'b1, mask.top};
  assign col_ok = {mask.right, 1'b1, mask.left};

  // Row sums first, then the total, to keep the adder chain short.
  always_comb begin
    cnt_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = '0;
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          row_sum[r] = row_sum[r] + SUM_W'(win_nxt[r][c]);
          cnt_nxt    = cnt_nxt + CNT_W'(1);
        end
      end
    end
    sum_nxt = row_sum[0] + row_sum[1] + row_sum[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (shift) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/core/bb3_out_stage.sv
// Normalizer and output register: sum times reciprocal of the count.
// Depends on bb3_pkg for recip() and the result flag struct.
module bb3_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [bb3_pkg::SUM_W-1:0]  sum,
  input  logic [bb3_pkg::CNT_W-1:0]  cnt,
  input  bb3_pkg::res_flags_t        flags,
  output logic                       can_load,
  bb3_out_if.source                  out_chan
);
  import bb3_pkg::*;

  logic [SUM_W+RECIP_W-1:0] prod;
  logic [PIX_W-1:0]         mean;
  logic                     valid_r;
  logic [PIX_W-1:0]         pix_r;
  res_flags_t               flags_r;

  assign prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(recip(cnt));
  assign mean = prod[RECIP_SH+PIX_W-1:RECIP_SH];

  assign can_load = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r   <= mean;
      flags_r <= flags;
    end
  end

  assign out_chan.valid         = valid_r;
  assign out_chan.blurred_pixel = pix_r;
  assign out_chan.end_of_row    = flags_r.eor;
  assign out_chan.end_of_frame  = flags_r.eof;

endmodule

### rtl/core/box_blur_3x3_edge_adaptive.sv
// Top level of the streaming 3x3 box filter with edge-adaptive averaging.
// Depends on bb3_pkg, bb3_if, bb3_line_ram, bb3_window, bb3_out_stage.
//
//   port       dir   words carried
//   in_chan    in    op, pixel_in
//   out_chan   out   blurred_pixel, end_of_row, end_of_frame
//   cfg_*      in    image_width (index 0), image_height (index 1)
//
// A pixel word that yields a result passes through accept and line RAM
// read, window update and RAM write-back, then normalize into the output
// register. A word without a result ends after the write-back, and an
// ignored drain after the accept. Reset is synchronous, active low, and
// needs no clearing pass. A full output register holds the normalize step
// until the word is taken; input waits meanwhile.
module box_blur_3x3_edge_adaptive (
  input  logic                           clk,
  input  logic                           rst_n,
  bb3_in_if.sink                         in_chan,
  bb3_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]      cfg_wdata
);
  import bb3_pkg::*;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W:0]   in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [PIX_W-1:0] pix_r;
  res_flags_t       flags_r;

  logic             accept;
  logic             take;
  logic             frame_in_done;
  logic             emit;
  logic             eor;
  logic             eof;
  logic             col_wrap;
  logic [PIX_W-1:0] fill_pix;
  mask_t            mask;
  col_t             new_col;
  logic             out_can_load;
  logic             out_load;

  logic               ram_rd_en;
  logic               ram_wr_en;
  logic [2*PIX_W-1:0] ram_rd_data;
  logic [2*PIX_W-1:0] ram_wr_data;

  logic [SUM_W-1:0] win_sum;
  logic [CNT_W-1:0] win_cnt;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign frame_in_done = (CFG_W'(in_row_r) >= height_r);
  // A drain word before the frame is complete changes nothing.
  assign take          = accept && !(in_chan.op == OP_DRAIN && !frame_in_done);

  assign emit     = (in_row_r >= (ROW_W+1)'(2)) ||
                    (in_row_r == (ROW_W+1)'(1) && in_col_r != '0);
  assign col_wrap = (CFG_W'(in_col_r) + CFG_W'(1)) >= width_r;
  assign fill_pix = frame_in_done ? '0 : pix_r;

  assign mask.top   = (out_row_r != '0);
  assign mask.bot   = (CFG_W'(out_row_r) + CFG_W'(1)) < height_r;
  assign mask.left  = (out_col_r != '0);
  assign mask.right = (CFG_W'(out_col_r) + CFG_W'(1)) < width_r;
  assign eor        = !mask.right;
  assign eof        = eor && !mask.bot;

  // Line RAM word: upper store in the high byte, lower store in the low byte.
  assign ram_rd_en   = take;
  assign ram_wr_en   = (state_r == S_RD);
  assign ram_wr_data = {ram_rd_data[PIX_W-1:0], fill_pix};

  assign new_col.up  = ram_rd_data[2*PIX_W-1:PIX_W];
  assign new_col.lo  = ram_rd_data[PIX_W-1:0];
  assign new_col.pix = fill_pix;

  assign out_load = (state_r == S_CALC) && out_can_load;

  bb3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2*PIX_W)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (in_col_r),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (in_col_r),
    .wr_data (ram_wr_data)
  );

  bb3_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (ram_wr_en),
    .col_in (new_col),
    .mask   (mask),
    .sum_r  (win_sum),
    .cnt_r  (win_cnt)
  );

  bb3_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .sum      (win_sum),
    .cnt      (win_cnt),
    .flags    (flags_r),
    .can_load (out_can_load),
    .out_chan (out_chan)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = emit ? S_CALC : S_IDLE;
      end
      S_CALC: begin
        if (out_can_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (state_r == S_RD) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + (ROW_W+1)'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (emit) begin
        if (eof) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (eor) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
    // A write to the width or height register restarts the frame.
    if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_nxt = clamp_dim(cfg_wdata, CFG_W'(MAX_WIDTH));
      end else begin
        height_nxt = clamp_dim(cfg_wdata, CFG_W'(MAX_HEIGHT));
      end
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      width_r   <= CFG_W'(640);
      height_r  <= CFG_W'(480);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_r <= in_chan.pixel_in;
    end
    if (state_r == S_RD) begin
      flags_r.eor <= eor;
      flags_r.eof <= eof;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_in_col_range, clk, rst_n, (CFG_W'(in_col_r) < width_r))
  `ASSERT_CLK(a_out_col_range, clk, rst_n, (CFG_W'(out_col_r) < width_r))
  `ASSERT_CLK(a_out_row_range, clk, rst_n, (CFG_W'(out_row_r) < height_r))
  `ASSERT_CLK(a_eof_restart, clk, rst_n, (ram_wr_en && emit && eof) |=> {in_row_r, out_row_r} == '0)
  `ASSERT_CLK(a_calc_loads, clk, rst_n, (state_r == S_CALC && out_can_load) |=> out_chan.valid)
  `ASSERT_NEVER(a_ram_rw_overlap, clk, rst_n, ram_rd_en && ram_wr_en)

endmodule

### test/tb_top.sv
// Self-checking bench for box_blur_3x3_edge_adaptive: frames of pixel words go in, and
// each blurred result is checked against a built-in line-buffer predictor.
// Depends on bb3_pkg, bb3_if and the box_blur_3x3_edge_adaptive RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bb3_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned CALM_ITEMS   = 100;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT     = 16;
  // Index with no register behind it; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum {PIX_MIXED, PIX_WHITE, PIX_BLACK} pix_mode_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             eor;
    logic             eof;
  } blur_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  bb3_in_if  in_ch ();
  bb3_out_if out_ch ();

  box_blur_3x3_edge_adaptive dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: line stores, window and frame positions.
  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] lower_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];
  int unsigned in_col, in_row, out_col, out_row;
  int unsigned img_w, img_h;

  blur_result_t blur_expect_q[$];
  blur_result_t want;

  int unsigned errors;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned hold_cycles;
  bit calm;
  pix_mode_t pix_mode;

  always #5 clk = ~clk;

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic logic [PIX_W-1:0] next_pixel();
    int unsigned r;
    if (pix_mode == PIX_WHITE) return 8'hFF;
    if (pix_mode == PIX_BLACK) return 8'h00;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return PIX_W'($urandom);
  endfunction

  function automatic void restart_positions();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    if (idx == REG_IMAGE_WIDTH) begin
      img_w = clamp_size(val, MAX_WIDTH);
      restart_positions();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      img_h = clamp_size(val, MAX_HEIGHT);
      restart_positions();
    end
  endfunction

  // Mean over the window cells whose position lies inside the frame.
  function automatic logic [PIX_W-1:0] window_mean();
    int r, c;
    int unsigned sum, cnt;
    sum = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      r = int'(out_row) + dr;
      if (r < 0 || r >= int'(img_h)) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        c = int'(out_col) + dc;
        if (c < 0 || c >= int'(img_w)) continue;
        sum += win[dr + 1][dc + 1];
        cnt++;
      end
    end
    if (cnt == 0) return '0;
    return PIX_W'(sum / cnt);
  endfunction

  function automatic void predict_blur(input logic op, input logic [PIX_W-1:0] pix_arg);
    bit frame_in_done, emit, eor, eof;
    int unsigned col;
    logic [PIX_W-1:0] pix, up, lo;
    blur_result_t res;
    pix = pix_arg;
    frame_in_done = in_row >= img_h;
    if (op == OP_DRAIN && !frame_in_done) return;
    // Once the frame is in, every word pushes a filler that is always masked.
    if (frame_in_done) pix = '0;
    col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
    up = upper_line[col];
    lo = lower_line[col];
    upper_line[col] = lo;
    lower_line[col] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = pix;
    emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= img_w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    eor = (out_col + 1) >= img_w;
    eof = eor && (out_row + 1) >= img_h;
    res.pix = window_mean();
    res.eor = eor;
    res.eof = eof;
    blur_expect_q.push_back(res);
    if (eof) begin
      restart_positions();
    end else begin
      out_col++;
      if (eor) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  task automatic send_word(input logic op, input logic [PIX_W-1:0] pix);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.pixel_in <= pix;
    do @(posedge clk); while (!in_ch.ready);
    predict_blur(op, pix);
  endtask

  // Stops offering words and waits until the block has nothing left in flight.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // One frame at the current size, then the flush. Noise adds stray drains
  // inside the frame and uses pixel words in the flush; cut drops flush words.
  task automatic send_frame(input int unsigned noise_pct, input int unsigned cut);
    int unsigned w, h, n;
    w = img_w;
    h = img_h;
    for (n = 0; n < w * h; n++) begin
      if ($urandom_range(99) < noise_pct) send_word(OP_DRAIN, PIX_W'($urandom));
      send_word(OP_PIXEL, next_pixel());
      items_sent++;
    end
    for (n = cut; n <= w; n++) begin
      if ($urandom_range(99) < noise_pct) send_word(OP_PIXEL, next_pixel());
      else send_word(OP_DRAIN, PIX_W'($urandom));
      items_sent++;
    end
  endtask

  // A zero width reads as one column and an oversized height saturates, so
  // this is the tallest frame the block supports.
  task automatic test_saturated_sizes();
    set_size(11'h000, 11'h7FF);
    send_frame(0, 0);
    settle();
  endtask

  task automatic test_tiny_frames();
    int unsigned dims [8][2] = '{'{1, 1}, '{2, 1}, '{1, 2}, '{2, 2},
                                 '{3, 1}, '{1, 3}, '{3, 3}, '{4, 3}};
    for (int i = 0; i < 8; i++) begin
      pix_mode = (i % 3 == 0) ? PIX_WHITE : (i % 3 == 1) ? PIX_BLACK : PIX_MIXED;
      set_size(CFG_W'(dims[i][0]), CFG_W'(dims[i][1]));
      send_frame(0, 0);
      settle();
    end
    pix_mode = PIX_MIXED;
  endtask

  task automatic test_unmapped_register();
    set_size(11'd3, 11'd2);
    write_reg(REG_UNMAPPED, 11'h7FF);
    send_frame(0, 0);
    settle();
  endtask

  task automatic test_stray_items();
    set_size(11'd3, 11'd2);
    send_word(OP_DRAIN, 8'hA5);
    for (int i = 0; i < 3; i++) send_word(OP_PIXEL, next_pixel());
    send_word(OP_DRAIN, 8'h5A);
    for (int i = 0; i < 3; i++) send_word(OP_PIXEL, next_pixel());
    // The frame is in: pixel words now only flush.
    for (int i = 0; i < 2; i++) send_word(OP_PIXEL, 8'hFF);
    for (int i = 0; i < 2; i++) send_word(OP_DRAIN, 8'h00);
    // Frame is complete and positions are back at zero, so these are ignored.
    for (int i = 0; i < 2; i++) send_word(OP_DRAIN, 8'hFF);
    send_frame(0, 0);
    settle();
  endtask

  task automatic test_restart_on_write();
    set_size(11'd4, 11'd3);
    for (int i = 0; i < 7; i++) send_word(OP_PIXEL, next_pixel());
    settle();
    write_reg(REG_IMAGE_WIDTH, 11'd5);
    send_frame(0, 0);
    settle();
  endtask

  task automatic test_back_pressure();
    set_size(11'd8, 11'd6);
    hold_cycles = 400;
    send_frame(0, 0);
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned w, h, start, kind;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      // The first stretch of words runs with no idling on either side.
      calm = (items_sent - start < CALM_ITEMS);
      if ($urandom_range(9) < 7) begin
        settle();
        kind = $urandom_range(9);
        if (kind < 2) begin
          w = $urandom_range(64, 17);
          h = $urandom_range(3, 0);
        end else begin
          w = $urandom_range(16, 0);
          h = $urandom_range(10, 0);
        end
        if ($urandom_range(1) == 0) begin
          set_size(CFG_W'(w), CFG_W'(h));
        end else begin
          write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
          write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        end
      end
      if ($urandom_range(19) == 0) send_frame(4, $urandom_range(img_w + 1, 1));
      else send_frame(4, 0);
    end
    calm = 1'b0;
    settle();
  endtask

  // Result side: checks each accepted word.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (blur_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pix %0d eor %0d eof %0d",
                 $time, out_ch.blurred_pixel, out_ch.end_of_row, out_ch.end_of_frame);
        errors++;
      end else begin
        want = blur_expect_q.pop_front();
        if (out_ch.blurred_pixel !== want.pix) begin
          $display("%0t: blurred_pixel expected %0d actual %0d",
                   $time, want.pix, out_ch.blurred_pixel);
          errors++;
        end
        if (out_ch.end_of_row !== want.eor) begin
          $display("%0t: end_of_row expected %0d actual %0d",
                   $time, want.eor, out_ch.end_of_row);
          errors++;
        end
        if (out_ch.end_of_frame !== want.eof) begin
          $display("%0t: end_of_frame expected %0d actual %0d",
                   $time, want.eof, out_ch.end_of_frame);
          errors++;
        end
      end
    end
  end

  // Result side ready: a counted hold when one is requested, random idling otherwise.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready <= !take_break();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** box_blur_3x3_edge_adaptive: FAILED **");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_PIXEL;
    in_ch.pixel_in = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    hold_cycles = 0;
    calm = 1'b0;
    pix_mode = PIX_MIXED;
    img_w = 640;
    img_h = 480;
    restart_positions();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_saturated_sizes();
    test_tiny_frames();
    test_unmapped_register();
    test_stray_items();
    test_restart_on_write();
    test_back_pressure();
    test_random_frames();

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && blur_expect_q.size() == 0) begin
      $display("** box_blur_3x3_edge_adaptive: PASSED **");
    end else begin
      $display("** box_blur_3x3_edge_adaptive: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bb3_pkg.sv
rtl/core/bb3_if.sv
rtl/core/bb3_line_ram.sv
rtl/core/bb3_window.sv
rtl/core/bb3_out_stage.sv
rtl/core/box_blur_3x3_edge_adaptive.sv
test/tb_top.sv
